/* design/dit_pkg.sv */
// Shared types and constants for the draw identity tagger.
package dit_pkg;

  localparam int GEN_W = 32;
  localparam int SUB_W = 16;

  localparam logic [SUB_W-1:0] SUB_IMMEDIATE = 16'hFFFF;
  localparam logic [SUB_W-1:0] RANK_CAP      = 16'hFFFE;
  localparam logic [SUB_W-1:0] ORD_MAX       = 16'hFFFF;
  localparam logic [GEN_W-1:0] GEN_MAX       = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    CMD_ID_NEW       = 4'd0,
    CMD_CTX_RESET    = 4'd1,
    CMD_CAMERA       = 4'd2,
    CMD_MODEL_BEGIN  = 4'd3,
    CMD_HOOK_BEGIN   = 4'd4,
    CMD_MODEL_END    = 4'd5,
    CMD_DEFER_RESET  = 4'd6,
    CMD_PUSH         = 4'd7,
    CMD_DEFER_BEGIN  = 4'd8,
    CMD_CAMERA_QUERY = 4'd9,
    CMD_NEXT         = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DCLR,
    ST_DTAIL
  } state_t;

endpackage

/* design/dit_ram.sv */
// Simple dual-port RAM, one write and one registered read per cycle.
module dit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/draw_identity_tagger.sv */
// Top level: command sequencer, draw context registers and identity memories.
//
//   channel   handshake            payload
//   command   start / busy         cmd, slot_index, hook_address
//   result    done (strobe)        key_valid, camera_out, model_slot_out,
//                                  generation_out, sub_out, ordinal_out
//
// Each command does a registered read of the model and defer memories, then
// the read-modify-write in the execute state and the registered result beat.
// Defer reset sweeps max(MODEL_SLOTS, DEFER_SLOTS) entries and then a tail
// state that writes the last pending rank, holding busy until its result beat.
// After reset, a clearing pass over max(MODEL_SLOTS, DEFER_SLOTS) entries holds
// busy high. The result beat lasts one cycle; the receiver cannot stall it.
module draw_identity_tagger #(
  parameter int MODEL_SLOTS  = 256,
  parameter int HOOK_SLOTS   = 8,
  parameter int CAMERA_SLOTS = 16,
  parameter int DEFER_SLOTS  = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [3:0]         cmd,
  input  logic signed [15:0] slot_index,
  input  logic [63:0]        hook_address,
  output logic               busy,
  output logic               done,
  output logic               key_valid,
  output logic signed [4:0]  camera_out,
  output logic [8:0]         model_slot_out,
  output logic [31:0]        generation_out,
  output logic [15:0]        sub_out,
  output logic [15:0]        ordinal_out
);

  localparam int GW    = dit_pkg::GEN_W;
  localparam int SW    = dit_pkg::SUB_W;
  localparam int MAW   = (MODEL_SLOTS > 1) ? $clog2(MODEL_SLOTS) : 1;
  localparam int DAW   = (DEFER_SLOTS > 1) ? $clog2(DEFER_SLOTS) : 1;
  localparam int HAW   = (HOOK_SLOTS > 1) ? $clog2(HOOK_SLOTS) : 1;
  localparam int CAW   = (CAMERA_SLOTS > 1) ? $clog2(CAMERA_SLOTS) : 1;
  localparam int SWEEP = (MODEL_SLOTS > DEFER_SLOTS) ? MODEL_SLOTS : DEFER_SLOTS;
  localparam int SCW   = (SWEEP > 1) ? $clog2(SWEEP) : 1;
  localparam int MEW   = GW + SW;
  localparam int DEW   = 1 + MAW + SW;

  dit_pkg::state_t state, state_next;
  dit_pkg::cmd_t   cmd_in, cmd_r;

  logic [SCW-1:0] cnt, cnt_next;
  logic           sweep_last;
  logic           pend;
  logic [MAW-1:0] pend_addr;

  // latched command
  logic [15:0] idx_r;
  logic        in_model_r, in_cam_r, in_hook_r, in_defer_r;
  logic [GW-1:0] hook_cand_r;

  // draw context
  logic           cam_v, cam_v_next;
  logic [CAW-1:0] cam, cam_next;
  logic           mdl_v, mdl_v_next;
  logic [MAW-1:0] mdl, mdl_next;
  logic           hk_v, hk_v_next;
  logic [HAW-1:0] hk, hk_next;
  logic [GW-1:0]  hook_gen, hook_gen_next;
  logic [SW-1:0]  sub, sub_next;
  logic [SW-1:0]  ord, ord_next;

  // input decode
  logic [31:0] idx_u;
  logic        idx_pos, in_model, in_cam, in_hook, in_defer, accept;

  // memories
  logic           mw_en, dw_en;
  logic [MAW-1:0] mw_addr, mr_addr;
  logic [DAW-1:0] dw_addr, dr_addr;
  logic [MEW-1:0] mw_data, mrd;
  logic [DEW-1:0] dw_data, drd;
  logic [GW-1:0]  gen_rd;
  logic [SW-1:0]  rank_rd;
  logic           dv_rd;
  logic [MAW-1:0] dm_rd;
  logic [SW-1:0]  ds_rd;

  // result
  logic          kv_c;
  logic [8:0]    slot_c;
  logic [GW-1:0] gen_c;
  logic [SW-1:0] sub_c, ord_c;

  assign cmd_in   = dit_pkg::cmd_t'(cmd);
  assign idx_u    = 32'(slot_index[14:0]);
  assign idx_pos  = !slot_index[15];
  assign in_model = idx_pos && (idx_u < 32'(MODEL_SLOTS));
  assign in_cam   = idx_pos && (idx_u < 32'(CAMERA_SLOTS));
  assign in_defer = idx_pos && (idx_u < 32'(DEFER_SLOTS));
  assign in_hook  = idx_pos && (idx_u < 32'(HOOK_SLOTS)) && (hook_address != 64'd0);
  assign accept   = start && (state == dit_pkg::ST_IDLE);
  assign busy     = (state != dit_pkg::ST_IDLE);

  assign sweep_last = (cnt == SCW'(SWEEP - 1));

  assign gen_rd  = mrd[MEW-1:SW];
  assign rank_rd = mrd[SW-1:0];
  assign dv_rd   = drd[DEW-1];
  assign dm_rd   = drd[DEW-2:SW];
  assign ds_rd   = drd[SW-1:0];

  assign mr_addr = (state != dit_pkg::ST_IDLE) ? cnt[MAW-1:0] :
                   ((cmd_in == dit_pkg::CMD_PUSH) || (cmd_in == dit_pkg::CMD_NEXT)) ? mdl :
                   slot_index[MAW-1:0];
  assign dr_addr = slot_index[DAW-1:0];

  assign camera_out = cam_v ? 5'(cam) : 5'h1F;

  dit_ram #(.WIDTH(MEW), .DEPTH(MODEL_SLOTS)) u_model_ram (
    .clk   (clk),
    .we    (mw_en),
    .waddr (mw_addr),
    .wdata (mw_data),
    .raddr (mr_addr),
    .rdata (mrd)
  );

  dit_ram #(.WIDTH(DEW), .DEPTH(DEFER_SLOTS)) u_defer_ram (
    .clk   (clk),
    .we    (dw_en),
    .waddr (dw_addr),
    .wdata (dw_data),
    .raddr (dr_addr),
    .rdata (drd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dit_pkg::ST_CLEAR;
      cnt      <= '0;
      pend     <= 1'b0;
      cam_v    <= 1'b0;
      mdl_v    <= 1'b0;
      hk_v     <= 1'b0;
      hook_gen <= '0;
      sub      <= dit_pkg::SUB_IMMEDIATE;
      ord      <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      pend     <= (state == dit_pkg::ST_DCLR) && (32'(cnt) < 32'(MODEL_SLOTS));
      cam_v    <= cam_v_next;
      mdl_v    <= mdl_v_next;
      hk_v     <= hk_v_next;
      hook_gen <= hook_gen_next;
      sub      <= sub_next;
      ord      <= ord_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= cnt[MAW-1:0];
    cam       <= cam_next;
    mdl       <= mdl_next;
    hk        <= hk_next;
    if (accept) begin
      cmd_r       <= cmd_in;
      idx_r       <= slot_index;
      in_model_r  <= in_model;
      in_cam_r    <= in_cam;
      in_hook_r   <= in_hook;
      in_defer_r  <= in_defer;
      hook_cand_r <= hook_address[35:4] | 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      key_valid <= 1'b0;
    end else begin
      done      <= (state == dit_pkg::ST_EXEC) || (state == dit_pkg::ST_DTAIL);
      key_valid <= kv_c;
    end
  end

  always_ff @(posedge clk) begin
    model_slot_out <= slot_c;
    generation_out <= gen_c;
    sub_out        <= sub_c;
    ordinal_out    <= ord_c;
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cam_v_next    = cam_v;
    cam_next      = cam;
    mdl_v_next    = mdl_v;
    mdl_next      = mdl;
    hk_v_next     = hk_v;
    hk_next       = hk;
    hook_gen_next = hook_gen;
    sub_next      = sub;
    ord_next      = ord;
    mw_en         = 1'b0;
    mw_addr       = cnt[MAW-1:0];
    mw_data       = '0;
    dw_en         = 1'b0;
    dw_addr       = cnt[DAW-1:0];
    dw_data       = '0;
    kv_c          = 1'b0;
    slot_c        = '0;
    gen_c         = '0;
    sub_c         = '0;
    ord_c         = '0;

    unique case (state)
      dit_pkg::ST_CLEAR: begin
        mw_en    = (32'(cnt) < 32'(MODEL_SLOTS));
        dw_en    = (32'(cnt) < 32'(DEFER_SLOTS));
        cnt_next = cnt + SCW'(1);
        if (sweep_last) begin
          state_next = dit_pkg::ST_IDLE;
        end
      end
      dit_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (start) begin
          state_next = (cmd_in == dit_pkg::CMD_DEFER_RESET) ? dit_pkg::ST_DCLR :
                       dit_pkg::ST_EXEC;
        end
      end
      dit_pkg::ST_EXEC: begin
        state_next = dit_pkg::ST_IDLE;
        unique case (cmd_r)
          dit_pkg::CMD_ID_NEW: begin
            if (in_model_r) begin
              mw_en   = 1'b1;
              mw_addr = idx_r[MAW-1:0];
              mw_data = {(gen_rd == dit_pkg::GEN_MAX) ? 32'd1 : gen_rd + 32'd1, rank_rd};
            end
          end
          dit_pkg::CMD_CTX_RESET: begin
            cam_v_next = 1'b0;
            mdl_v_next = 1'b0;
            hk_v_next  = 1'b0;
            sub_next   = dit_pkg::SUB_IMMEDIATE;
            ord_next   = '0;
          end
          dit_pkg::CMD_CAMERA: begin
            cam_v_next = in_cam_r;
            cam_next   = idx_r[CAW-1:0];
            mdl_v_next = 1'b0;
            hk_v_next  = 1'b0;
            sub_next   = dit_pkg::SUB_IMMEDIATE;
            ord_next   = '0;
          end
          dit_pkg::CMD_MODEL_BEGIN: begin
            if (in_model_r) begin
              mw_en      = (gen_rd == '0);
              mw_addr    = idx_r[MAW-1:0];
              mw_data    = {32'd1, rank_rd};
              mdl_v_next = 1'b1;
              mdl_next   = idx_r[MAW-1:0];
            end else begin
              mdl_v_next = 1'b0;
            end
            hk_v_next = 1'b0;
            sub_next  = dit_pkg::SUB_IMMEDIATE;
            ord_next  = '0;
          end
          dit_pkg::CMD_HOOK_BEGIN: begin
            mdl_v_next = 1'b0;
            sub_next   = dit_pkg::SUB_IMMEDIATE;
            ord_next   = '0;
            hk_v_next  = in_hook_r;
            if (in_hook_r) begin
              hk_next       = idx_r[HAW-1:0];
              hook_gen_next = hook_cand_r;
            end
          end
          dit_pkg::CMD_MODEL_END: begin
            mdl_v_next = 1'b0;
            hk_v_next  = 1'b0;
            sub_next   = dit_pkg::SUB_IMMEDIATE;
            ord_next   = '0;
          end
          dit_pkg::CMD_PUSH: begin
            if (in_defer_r) begin
              dw_en   = 1'b1;
              dw_addr = idx_r[DAW-1:0];
              if (mdl_v) begin
                dw_data = {1'b1, mdl, rank_rd};
                mw_en   = 1'b1;
                mw_addr = mdl;
                mw_data = {gen_rd, (rank_rd < dit_pkg::RANK_CAP) ? rank_rd + 16'd1 : rank_rd};
              end else begin
                dw_data = {1'b0, MAW'(0), dit_pkg::SUB_IMMEDIATE};
              end
            end
          end
          dit_pkg::CMD_DEFER_BEGIN: begin
            ord_next  = '0;
            hk_v_next = 1'b0;
            if (in_defer_r && dv_rd) begin
              mdl_v_next = 1'b1;
              mdl_next   = dm_rd;
              sub_next   = ds_rd;
            end else begin
              mdl_v_next = 1'b0;
              sub_next   = dit_pkg::SUB_IMMEDIATE;
            end
          end
          dit_pkg::CMD_NEXT: begin
            if (cam_v && (mdl_v || hk_v)) begin
              kv_c   = 1'b1;
              slot_c = mdl_v ? 9'(mdl) : 9'(32'(MODEL_SLOTS) + 32'(hk));
              gen_c  = mdl_v ? gen_rd : hook_gen;
              sub_c  = sub;
              ord_c  = ord;
              if (ord != dit_pkg::ORD_MAX) begin
                ord_next = ord + 16'd1;
              end
            end
          end
          dit_pkg::CMD_DEFER_RESET, dit_pkg::CMD_CAMERA_QUERY: begin
          end
          default: begin
          end
        endcase
      end
      dit_pkg::ST_DCLR: begin
        // rank cleared, generation kept: written back in the cycle after the read
        mw_en    = pend;
        mw_addr  = pend_addr;
        mw_data  = {gen_rd, SW'(0)};
        dw_en    = (32'(cnt) < 32'(DEFER_SLOTS));
        cnt_next = cnt + SCW'(1);
        if (sweep_last) begin
          state_next = dit_pkg::ST_DTAIL;
        end
      end
      dit_pkg::ST_DTAIL: begin
        mw_en      = pend;
        mw_addr    = pend_addr;
        mw_data    = {gen_rd, SW'(0)};
        state_next = dit_pkg::ST_IDLE;
      end
      default: begin
        state_next = dit_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

/* design/dit_checker.sv */
// Port-level checks for the draw identity tagger, bound to the top level.
module dit_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic [3:0]  cmd,
  input logic        busy,
  input logic        done,
  input logic        key_valid,
  input logic [8:0]  model_slot_out,
  input logic [31:0] generation_out,
  input logic [15:0] sub_out,
  input logic [15:0] ordinal_out
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_cmd_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd != 4'(dit_pkg::CMD_DEFER_RESET))) |-> ##2 done)
    else $error("missing result beat two cycles after command");

  a_key_strobe: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> done)
    else $error("key valid outside a result beat");

  a_no_key_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !key_valid) |-> (model_slot_out == 9'd0) && (generation_out == 32'd0) &&
                             (sub_out == 16'd0) && (ordinal_out == 16'd0))
    else $error("key fields not zero without a key");

endmodule

bind draw_identity_tagger dit_checker u_dit_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .cmd            (cmd),
  .busy           (busy),
  .done           (done),
  .key_valid      (key_valid),
  .model_slot_out (model_slot_out),
  .generation_out (generation_out),
  .sub_out        (sub_out),
  .ordinal_out    (ordinal_out)
);
